[design/kihlp_pkg.sv]
// Shared types, constants and codes for the key import header list parser.
package kihlp_pkg;

  localparam int OffW     = 20;
  localparam logic [OffW-1:0] OffMax = 20'hFFFFF;
  localparam int PosW     = 21;
  localparam int NumComp  = 7;
  localparam int CompIdxW = 3;
  localparam int LenW     = 16;

  localparam logic [7:0]  TagExtMask  = 8'h1F;
  localparam logic [7:0]  LenShortMax = 8'h7F;
  localparam logic [7:0]  LenForm81   = 8'h81;
  localparam logic [7:0]  LenForm82   = 8'h82;
  localparam logic [15:0] TagOuter    = 16'h004D;
  localparam logic [15:0] TagTemplate = 16'h7F48;
  localparam logic [15:0] TagKeyData  = 16'h5F48;
  localparam logic [15:0] TagSlotSig  = 16'h00B6;
  localparam logic [15:0] TagSlotDec  = 16'h00B8;
  localparam logic [15:0] TagSlotAuth = 16'h00A4;
  localparam logic [15:0] TagReject   = 16'h0099;
  localparam logic [15:0] TagCompLo   = 16'h0091;
  localparam logic [15:0] TagCompHi   = 16'h0097;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_LEN_FORM = 3'd1,
    STAT_KEY      = 3'd2,
    STAT_TAG      = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_SIG  = 2'd0,
    SLOT_DEC  = 2'd1,
    SLOT_AUTH = 2'd2
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TAG0,
    ST_TAG1,
    ST_LEN0,
    ST_LEN81,
    ST_LEN82H,
    ST_LEN82L,
    ST_SUM,
    ST_CHECK,
    ST_EMIT,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    HS_OUTER,
    HS_SLOT,
    HS_TEMPLATE,
    HS_INNER,
    HS_KEYDATA
  } hdr_stage_t;

  typedef enum logic {
    LEN_BYTE,
    LEN_WORD
  } len_sel_t;

  typedef struct packed {
    logic       begin_cmd;
    logic       take_byte;
    logic       load_tag0;
    logic       load_tag1;
    logic       load_len_hi;
    len_sel_t   len_sel;
    logic       set_slot;
    logic       set_template;
    logic       set_comp;
    logic       sum_start;
    logic       sum_step;
    logic       emit_start;
    logic       emit_rec;
    logic       emit_err;
    status_t    err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_ext;
    logic len_short;
    logic len_81;
    logic len_82;
    logic tag_outer;
    logic tag_slot_ok;
    logic tag_template;
    logic tag_reject;
    logic tag_keydata;
    logic tmpl_empty;
    logic inner_done;
    logic over;
    logic cnt_last;
    logic out_free;
  } dp_status_t;

endpackage

[design/key_import_header_list_parser_unit.sv]
// Top level of the key import header list parser: controller plus datapath.
// Latency: a header or length form error record sits in the output register the cycle after
// its byte; the range error after the 5F48 header is loaded from ST_CHECK once the sum is done.
// Throughput: one input transaction per cycle while parsing and the output register is free;
// after the 5F48 header the sum over the seven component lengths (ST_SUM), the compare
// (ST_CHECK) and the seven records (ST_EMIT, held while the sink stalls) take no input.
// Reset (rst, synchronous, active high) returns to idle; bytes before a begin are ignored.
module key_import_header_list_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] data_byte, [23:8] command_length
  input  logic        s_tuser,   // [0] op: 0 begin, 1 data byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] status, [4:3] key_slot, [7:5] component,
                                 // [23:8] comp_offset, [39:24] comp_length
  output logic        m_tlast    // last record of the run
);
  import kihlp_pkg::*;

  // The controller sequences header bytes and the record emission; the datapath holds the
  // accumulators, offsets, the seven component lengths and the registered result.
  dp_cmd_t    cmd;
  dp_status_t st;

  kihlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // Input is held off while a record waits in the output register and the sink is not ready.
  kihlp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .byte_in   (s_tdata[7:0]),
    .lc_in     (s_tdata[23:8]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

[design/kihlp_dp.sv]
// Datapath of the parser: header accumulators, offsets, component lengths and output register.
module kihlp_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  kihlp_pkg::dp_cmd_t    cmd,
  output kihlp_pkg::dp_status_t st,
  input  logic [7:0]            byte_in,
  input  logic [15:0]           lc_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [39:0]           out_data,
  output logic                  out_last
);
  import kihlp_pkg::*;

  logic [15:0]         tag_accum;
  logic [7:0]          len_hi;
  logic [OffW-1:0]     byte_offset;
  logic [OffW-1:0]     template_end;
  logic [1:0]          slot_reg;
  logic [15:0]         lc_reg;
  logic [LenW-1:0]     comp_lengths [NumComp];
  logic [CompIdxW-1:0] cnt;
  logic [PosW-1:0]     pos;

  logic [2:0]          o_status;
  logic [1:0]          o_slot;
  logic [2:0]          o_comp;
  logic [15:0]         o_offset;
  logic [15:0]         o_length;

  logic [LenW-1:0]     hdr_len;
  logic [OffW-1:0]     bo_inc;
  logic [PosW-1:0]     te_sum;
  logic [OffW-1:0]     te_new;
  logic                comp_tag;
  logic [7:0]          comp_diff;
  logic [CompIdxW-1:0] comp_idx;
  logic [LenW-1:0]     cur_len;

  always_comb begin
    hdr_len   = (cmd.len_sel == LEN_WORD) ? {len_hi, byte_in} : {8'h00, byte_in};
    bo_inc    = (byte_offset != OffMax) ? byte_offset + 1'b1 : byte_offset;
    te_sum    = {1'b0, bo_inc} + PosW'(hdr_len);
    te_new    = (te_sum > {1'b0, OffMax}) ? OffMax : te_sum[OffW-1:0];
    comp_tag  = (tag_accum >= TagCompLo) && (tag_accum <= TagCompHi);
    comp_diff = tag_accum[7:0] - TagCompLo[7:0];
    comp_idx  = comp_diff[CompIdxW-1:0];
    cur_len   = comp_lengths[cnt];

    st.tag_ext      = ((byte_in & TagExtMask) == TagExtMask);
    st.len_short    = (byte_in <= LenShortMax);
    st.len_81       = (byte_in == LenForm81);
    st.len_82       = (byte_in == LenForm82);
    st.tag_outer    = (tag_accum == TagOuter);
    st.tag_slot_ok  = (tag_accum == TagSlotSig) || (tag_accum == TagSlotDec) ||
                      (tag_accum == TagSlotAuth);
    st.tag_template = (tag_accum == TagTemplate);
    st.tag_reject   = (tag_accum == TagReject);
    st.tag_keydata  = (tag_accum == TagKeyData);
    st.tmpl_empty   = (bo_inc >= te_new);
    st.inner_done   = (bo_inc >= template_end);
    st.over         = (pos > PosW'(lc_reg));
    st.cnt_last     = (cnt == CompIdxW'(NumComp - 1));
    st.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_accum    <= '0;
      len_hi       <= '0;
      byte_offset  <= '0;
      template_end <= '0;
      slot_reg     <= SLOT_SIG;
      lc_reg       <= '0;
      cnt          <= '0;
      pos          <= '0;
      for (int i = 0; i < NumComp; i++) begin
        comp_lengths[i] <= '0;
      end
    end else if (cmd.begin_cmd) begin
      tag_accum    <= '0;
      len_hi       <= '0;
      byte_offset  <= '0;
      template_end <= '0;
      slot_reg     <= SLOT_SIG;
      lc_reg       <= lc_in;
      for (int i = 0; i < NumComp; i++) begin
        comp_lengths[i] <= '0;
      end
    end else begin
      if (cmd.take_byte) begin
        byte_offset <= bo_inc;
      end
      if (cmd.load_tag0) begin
        tag_accum <= {8'h00, byte_in};
      end
      if (cmd.load_tag1) begin
        tag_accum <= {tag_accum[7:0], byte_in};
      end
      if (cmd.load_len_hi) begin
        len_hi <= byte_in;
      end
      if (cmd.set_slot) begin
        if (tag_accum == TagSlotDec) begin
          slot_reg <= SLOT_DEC;
        end else if (tag_accum == TagSlotAuth) begin
          slot_reg <= SLOT_AUTH;
        end else begin
          slot_reg <= SLOT_SIG;
        end
      end
      if (cmd.set_template) begin
        template_end <= te_new;
      end
      if (cmd.set_comp && comp_tag) begin
        comp_lengths[comp_idx] <= hdr_len;
      end
      if (cmd.sum_start) begin
        pos <= {1'b0, bo_inc};
        cnt <= '0;
      end
      if (cmd.emit_start) begin
        pos <= {1'b0, byte_offset};
        cnt <= '0;
      end
      if (cmd.sum_step || cmd.emit_rec) begin
        pos <= pos + PosW'(cur_len);
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output register: valid is control, the record fields are payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_rec || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      o_status <= cmd.err_code;
      o_slot   <= '0;
      o_comp   <= '0;
      o_offset <= '0;
      o_length <= '0;
      out_last <= 1'b1;
    end else if (cmd.emit_rec) begin
      o_status <= STAT_OK;
      o_slot   <= slot_reg;
      o_comp   <= cnt;
      o_offset <= pos[15:0];
      o_length <= cur_len;
      out_last <= st.cnt_last;
    end
  end

  assign out_data = {o_length, o_offset, o_comp, o_slot, o_status};

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.sum_step || cmd.emit_rec) |-> (cnt <= CompIdxW'(NumComp - 1)))
    else $error("component index stepped beyond the last component");

  a_emit_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_rec && st.cnt_last) |=> (out_valid && out_last && (o_comp == 3'd6)))
    else $error("final component record lacks its last flag");

endmodule

[design/kihlp_ctrl.sv]
// Controller state machine: header byte sequencing, header order checks and record emission.
module kihlp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  input  kihlp_pkg::dp_status_t st,
  output kihlp_pkg::dp_cmd_t    cmd
);
  import kihlp_pkg::*;

  ctl_state_t state, state_next;
  hdr_stage_t stage, stage_next;
  logic       accepted;
  logic       hdr_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= HS_OUTER;
    end else begin
      state <= state_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    state_next = state;
    stage_next = stage;
    cmd        = '0;
    hdr_done   = 1'b0;
    in_ready   = 1'b0;

    unique case (state)
      ST_IDLE, ST_DONE, ST_TAG0, ST_TAG1, ST_LEN0, ST_LEN81, ST_LEN82H, ST_LEN82L: begin
        in_ready = st.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    accepted = in_valid && in_ready;

    if (accepted && !in_op) begin
      cmd.begin_cmd = 1'b1;
      state_next    = ST_TAG0;
      stage_next    = HS_OUTER;
    end else begin
      unique case (state)
        ST_IDLE, ST_DONE: begin
          state_next = state;
        end
        ST_TAG0: begin
          if (accepted) begin
            cmd.take_byte = 1'b1;
            cmd.load_tag0 = 1'b1;
            state_next    = st.tag_ext ? ST_TAG1 : ST_LEN0;
          end
        end
        ST_TAG1: begin
          if (accepted) begin
            cmd.take_byte = 1'b1;
            cmd.load_tag1 = 1'b1;
            state_next    = ST_LEN0;
          end
        end
        ST_LEN0: begin
          if (accepted) begin
            cmd.take_byte = 1'b1;
            if (st.len_short) begin
              hdr_done = 1'b1;
            end else if (st.len_81) begin
              state_next = ST_LEN81;
            end else if (st.len_82) begin
              state_next = ST_LEN82H;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_LEN_FORM;
              state_next   = ST_DONE;
            end
          end
        end
        ST_LEN81: begin
          if (accepted) begin
            cmd.take_byte = 1'b1;
            hdr_done      = 1'b1;
          end
        end
        ST_LEN82H: begin
          if (accepted) begin
            cmd.take_byte   = 1'b1;
            cmd.load_len_hi = 1'b1;
            state_next      = ST_LEN82L;
          end
        end
        ST_LEN82L: begin
          if (accepted) begin
            cmd.take_byte = 1'b1;
            cmd.len_sel   = LEN_WORD;
            hdr_done      = 1'b1;
          end
        end
        ST_SUM: begin
          cmd.sum_step = 1'b1;
          if (st.cnt_last) begin
            state_next = ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (st.over) begin
            if (st.out_free) begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_RANGE;
              state_next   = ST_DONE;
            end
          end else begin
            cmd.emit_start = 1'b1;
            state_next     = ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (st.out_free) begin
            cmd.emit_rec = 1'b1;
            if (st.cnt_last) begin
              state_next = ST_DONE;
            end
          end
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase

      // A complete header: check it against the expected position in the list.
      if (hdr_done) begin
        state_next = ST_TAG0;
        unique case (stage)
          HS_OUTER: begin
            if (st.tag_outer) begin
              stage_next = HS_SLOT;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_TAG;
              state_next   = ST_DONE;
            end
          end
          HS_SLOT: begin
            if (st.tag_slot_ok) begin
              cmd.set_slot = 1'b1;
              stage_next   = HS_TEMPLATE;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_KEY;
              state_next   = ST_DONE;
            end
          end
          HS_TEMPLATE: begin
            if (st.tag_template) begin
              cmd.set_template = 1'b1;
              stage_next       = st.tmpl_empty ? HS_KEYDATA : HS_INNER;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_TAG;
              state_next   = ST_DONE;
            end
          end
          HS_INNER: begin
            if (st.tag_reject) begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_KEY;
              state_next   = ST_DONE;
            end else begin
              cmd.set_comp = 1'b1;
              if (st.inner_done) begin
                stage_next = HS_KEYDATA;
              end
            end
          end
          HS_KEYDATA: begin
            if (st.tag_keydata) begin
              cmd.sum_start = 1'b1;
              state_next    = ST_SUM;
            end else begin
              cmd.emit_err = 1'b1;
              cmd.err_code = STAT_TAG;
              state_next   = ST_DONE;
            end
          end
          default: begin
            cmd.emit_err = 1'b1;
            cmd.err_code = STAT_TAG;
            state_next   = ST_DONE;
          end
        endcase
      end
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM || state == ST_CHECK || state == ST_EMIT) |-> !in_ready)
    else $error("input accepted while the component records are being produced");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_rec || cmd.emit_err) |-> st.out_free)
    else $error("output record loaded while an earlier one is still pending");

  a_begin_restarts: assert property (@(posedge clk) disable iff (rst)
    (accepted && !in_op) |=> (state == ST_TAG0 && stage == HS_OUTER))
    else $error("begin transaction did not restart the header list");

  a_last_record_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && cmd.emit_rec && st.cnt_last) |=> (state == ST_DONE))
    else $error("emission continued past the seventh component");

endmodule

[tb/sv/tb_key_import_header_list_parser_unit.sv]
// Self-checking testbench for the key import header list parser with a scoreboard class.
`timescale 1ns / 100ps

module tb_key_import_header_list_parser_unit;
  import kihlp_pkg::*;

  // The idle limit covers the long receiver hold-off plus a full emission several times.
  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 410;
  localparam int PauseAfter  = 200;

  // One output record as it appears on {m_tlast, m_tdata}, lowest field last.
  typedef struct packed {
    logic        last;
    logic [15:0] comp_length;
    logic [15:0] comp_offset;
    logic [2:0]  component;
    slot_t       key_slot;
    status_t     status;
  } key_rec_t;

  // One input transaction: op on tuser, {command_length, data_byte} on tdata.
  typedef struct {
    bit          op;
    logic [7:0]  data;
    logic [15:0] lc;
  } stim_t;

  // Ways a generated command is shaped: well formed, or broken in one of several ways.
  typedef enum {
    FORM_GOOD,
    FORM_CUT,
    FORM_OVERWRITE,
    FORM_REJECT,
    FORM_NOISE
  } cmd_form_t;

  // Scoreboard: tracks the parser state for each accepted input transaction and keeps
  // the records that the block must produce, oldest first.
  class key_record_board;
    ctl_state_t  parse_phase;
    hdr_stage_t  hdr_stage;
    logic [15:0] tag_acc;
    logic [15:0] len_acc;
    logic [OffW-1:0] offset;
    logic [OffW-1:0] tmpl_end;
    slot_t       slot;
    logic [15:0] lc;
    logic [15:0] lens [NumComp];
    key_rec_t    expected_records [$];
    int unsigned mismatches, records_seen, inputs, begins, good_runs, error_runs;

    function new();
      clear_parser();
      parse_phase = ST_IDLE;
      lc = '0;
    endfunction

    function void clear_parser();
      parse_phase = ST_IDLE;
      hdr_stage = HS_OUTER;
      tag_acc = '0;
      len_acc = '0;
      offset = '0;
      tmpl_end = '0;
      slot = SLOT_SIG;
      foreach (lens[i]) lens[i] = '0;
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    function void push_error(status_t code);
      key_rec_t rec;
      rec = '0;
      rec.status = code;
      rec.last = 1'b1;
      expected_records.push_back(rec);
      error_runs++;
      parse_phase = ST_DONE;
    endfunction

    // Key data header seen: either seven component records or a range error.
    function void emit_components();
      int unsigned pos;
      key_rec_t rec;
      pos = offset;
      foreach (lens[k]) pos += lens[k];
      if (pos > lc) begin
        push_error(STAT_RANGE);
        return;
      end
      pos = offset;
      for (int k = 0; k < NumComp; k++) begin
        rec.status = STAT_OK;
        rec.key_slot = slot;
        rec.component = 3'(k);
        rec.comp_offset = pos[15:0];
        rec.comp_length = lens[k];
        rec.last = (k == NumComp - 1);
        expected_records.push_back(rec);
        pos += lens[k];
      end
      good_runs++;
      parse_phase = ST_DONE;
    endfunction

    function void finish_header();
      int unsigned tail;
      parse_phase = ST_TAG0;
      case (hdr_stage)
        HS_OUTER: begin
          if (tag_acc != TagOuter) push_error(STAT_TAG);
          else hdr_stage = HS_SLOT;
        end
        HS_SLOT: begin
          if (tag_acc == TagSlotSig) slot = SLOT_SIG;
          else if (tag_acc == TagSlotDec) slot = SLOT_DEC;
          else if (tag_acc == TagSlotAuth) slot = SLOT_AUTH;
          else begin
            push_error(STAT_KEY);
            return;
          end
          hdr_stage = HS_TEMPLATE;
        end
        HS_TEMPLATE: begin
          if (tag_acc != TagTemplate) begin
            push_error(STAT_TAG);
            return;
          end
          tail = offset + len_acc;
          if (tail > OffMax) tail = OffMax;
          tmpl_end = tail[OffW-1:0];
          if (offset >= tmpl_end) hdr_stage = HS_KEYDATA;
          else hdr_stage = HS_INNER;
        end
        HS_INNER: begin
          if (tag_acc >= TagCompLo && tag_acc <= TagCompHi) begin
            lens[tag_acc - TagCompLo] = len_acc;
          end else if (tag_acc == TagReject) begin
            push_error(STAT_KEY);
            return;
          end
          if (offset >= tmpl_end) hdr_stage = HS_KEYDATA;
        end
        default: begin
          if (tag_acc != TagKeyData) push_error(STAT_TAG);
          else emit_components();
        end
      endcase
    endfunction

    // Called for every accepted input transaction.
    function void note_input(bit op, logic [7:0] b, logic [15:0] cmd_len);
      inputs++;
      if (!op) begin
        clear_parser();
        lc = cmd_len;
        parse_phase = ST_TAG0;
        begins++;
        return;
      end
      if (parse_phase == ST_IDLE || parse_phase == ST_DONE) return;
      if (offset < OffMax) offset++;
      case (parse_phase)
        ST_TAG0: begin
          tag_acc = {8'h00, b};
          if ((b & TagExtMask) == TagExtMask) parse_phase = ST_TAG1;
          else parse_phase = ST_LEN0;
        end
        ST_TAG1: begin
          tag_acc = {tag_acc[7:0], b};
          parse_phase = ST_LEN0;
        end
        ST_LEN0: begin
          if (b <= LenShortMax) begin
            len_acc = {8'h00, b};
            finish_header();
          end else if (b == LenForm81) begin
            parse_phase = ST_LEN81;
          end else if (b == LenForm82) begin
            parse_phase = ST_LEN82H;
          end else begin
            push_error(STAT_LEN_FORM);
          end
        end
        ST_LEN81: begin
          len_acc = {8'h00, b};
          finish_header();
        end
        ST_LEN82H: begin
          len_acc = {b, 8'h00};
          parse_phase = ST_LEN82L;
        end
        default: begin
          len_acc = {len_acc[15:8], b};
          finish_header();
        end
      endcase
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    // Called for every accepted output transaction.
    function void check_record(logic [39:0] data, logic tlast);
      key_rec_t got, want;
      got = key_rec_t'({tlast, data});
      records_seen++;
      if (expected_records.size() == 0) begin
        $display("%0t: record %h arrived with none expected", $time, {tlast, data});
        mismatches++;
        return;
      end
      want = expected_records.pop_front();
      check_field("status", want.status, got.status);
      check_field("key_slot", want.key_slot, got.key_slot);
      check_field("component", want.component, got.component);
      check_field("comp_offset", want.comp_offset, got.comp_offset);
      check_field("comp_length", want.comp_length, got.comp_length);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // [7:0] data_byte, [23:8] command_length
  logic        s_tuser;   // [0] op: 0 begin, 1 data byte
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [2:0] status, [4:3] key_slot, [7:5] component,
                          // [23:8] comp_offset, [39:24] comp_length
  logic        m_tlast;

  key_record_board sb = new();
  stim_t       stim_q [$];
  logic [7:0]  cmd_bytes [$];
  int unsigned idle_cycles = 0;

  key_import_header_list_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  // Component lengths are mostly small; a few use the full 16-bit range.
  function automatic int unsigned rand_comp_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 40);
    if (r < 9) return $urandom_range(0, 255);
    if ($urandom_range(0, 1)) return 16'hFFFF;
    return $urandom_range(0, 65535);
  endfunction

  // The unused field of each transaction carries random bits, since the block ignores it.
  function automatic void add_begin(logic [15:0] lc);
    stim_t it;
    it.op = 1'b0;
    it.data = 8'($urandom_range(0, 255));
    it.lc = lc;
    stim_q.push_back(it);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    stim_t it;
    it.op = 1'b1;
    it.data = b;
    it.lc = 16'($urandom_range(0, 65535));
    stim_q.push_back(it);
  endfunction

  // Length in short, 81 or 82 form; short values pick the long forms now and then.
  function automatic void put_len(int unsigned v);
    int unsigned form;
    if (v > 255) form = 2;
    else if (v > 127) form = $urandom_range(1, 2);
    else if ($urandom_range(0, 3) == 0) form = $urandom_range(1, 2);
    else form = 0;
    case (form)
      0: cmd_bytes.push_back(8'(v));
      1: begin
        cmd_bytes.push_back(LenForm81);
        cmd_bytes.push_back(8'(v));
      end
      default: begin
        cmd_bytes.push_back(LenForm82);
        cmd_bytes.push_back(8'(v >> 8));
        cmd_bytes.push_back(8'(v));
      end
    endcase
  endfunction

  function automatic void put_hdr(logic [15:0] tag, bit two_byte, int unsigned len);
    if (two_byte) cmd_bytes.push_back(tag[15:8]);
    cmd_bytes.push_back(tag[7:0]);
    put_len(len);
  endfunction

  // Builds one command: a begin transaction and its data bytes. Most commands are well
  // formed with random content so the parser gets through every header stage; the rest
  // are cut short, carry a corrupted byte, a rejected tag, or are plain noise.
  function automatic void make_command();
    logic [7:0]  inner [$];
    int unsigned clen [NumComp];
    int unsigned n, k, len, total, r, lc, cut;
    logic [7:0]  t;
    logic [15:0] slot_tag;
    cmd_form_t   form;

    cmd_bytes.delete();
    foreach (clen[i]) clen[i] = 0;
    total = 0;
    r = $urandom_range(0, 99);
    if (r < 70) form = FORM_GOOD;
    else if (r < 78) form = FORM_CUT;
    else if (r < 86) form = FORM_OVERWRITE;
    else if (r < 93) form = FORM_REJECT;
    else form = FORM_NOISE;

    if (form == FORM_NOISE) begin
      n = $urandom_range(3, 12);
      repeat (n) cmd_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      // Headers inside the template come first so that its length is known.
      n = $urandom_range(0, 9);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, NumComp - 1);
          len = rand_comp_len();
          put_hdr(16'(TagCompLo + k), 1'b0, len);
          clen[k] = len;
        end else if ($urandom_range(0, 1)) begin
          do t = 8'($urandom_range(0, 255));
          while ((t >= TagCompLo[7:0] && t <= TagCompHi[7:0]) || t == TagReject[7:0] ||
                 (t & TagExtMask) == TagExtMask);
          put_hdr({8'h00, t}, 1'b0, $urandom_range(0, 40));
        end else begin
          t = 8'($urandom_range(0, 7) << 5) | TagExtMask;
          put_hdr({t, 8'($urandom_range(0, 255))}, 1'b1, $urandom_range(0, 40));
        end
      end
      if (form == FORM_REJECT) put_hdr(TagReject, 1'b0, $urandom_range(0, 40));
      inner = cmd_bytes;
      cmd_bytes.delete();

      case ($urandom_range(0, 2))
        0: slot_tag = TagSlotSig;
        1: slot_tag = TagSlotDec;
        default: slot_tag = TagSlotAuth;
      endcase
      put_hdr(TagOuter, 1'b0, $urandom_range(0, 300));
      put_hdr(slot_tag, 1'b0, $urandom_range(0, 300));
      put_hdr(TagTemplate, 1'b1, inner.size());
      foreach (inner[i]) cmd_bytes.push_back(inner[i]);
      put_hdr(TagKeyData, 1'b1, $urandom_range(0, 300));
      total = cmd_bytes.size();
      foreach (clen[i]) total += clen[i];
      // A few key bytes follow; the parser ignores them.
      repeat ($urandom_range(0, 3)) cmd_bytes.push_back(8'($urandom_range(0, 255)));

      if (form == FORM_CUT) begin
        cut = $urandom_range(1, cmd_bytes.size() - 1);
        while (cmd_bytes.size() > cut) void'(cmd_bytes.pop_back());
      end else if (form == FORM_OVERWRITE) begin
        cmd_bytes[$urandom_range(0, cmd_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end

    // Command length: the extremes, just enough or more, a little too short, or random.
    r = $urandom_range(0, 99);
    if (r < 10) lc = 16'hFFFF;
    else if (r < 15) lc = 0;
    else if (total > 16'hFFFF || r >= 85) lc = $urandom_range(0, 65535);
    else if (r < 60) begin
      lc = total + $urandom_range(0, 20);
      if (lc > 16'hFFFF) lc = 16'hFFFF;
    end else if (total == 0) lc = 0;
    else lc = total - $urandom_range(1, (total < 4) ? total : 4);

    add_begin(16'(lc));
    foreach (cmd_bytes[i]) add_byte(cmd_bytes[i]);
  endfunction

  // Drives one input transaction and returns at the falling edge after it was accepted.
  task automatic send_item(stim_t it);
    s_tvalid = 1'b1;
    s_tuser = it.op;
    s_tdata = {it.lc, it.data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Monitor: every accepted transaction on either side goes to the scoreboard. The input
  // side is noted first, although a record never leaves in the cycle of its cause.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[7:0], s_tdata[23:8]);
      if (m_tvalid && m_tready) sb.check_record(m_tdata, m_tlast);
    end
  end

  // Receiver: random stalls of mixed length, stretches with none, and once a long
  // hold-off while a record is waiting, so the block fills and stops taking input.
  initial begin
    int unsigned stall_left;
    bit burst, held;
    stall_left = 0;
    burst = 1'b0;
    held = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.records_seen >= 20 && m_tvalid) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 63) == 0) burst = !burst;
        if (!burst && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // Watchdog: ends the run when nothing has been accepted for too long.
  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // Sender and end of run.
  initial begin
    stim_t it;
    int unsigned n_sent, g;
    bit paused, burst;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    n_sent = 0;
    paused = 1'b0;
    burst = 1'b0;

    // Directed: bytes before any begin are ignored.
    add_byte(8'hFF);
    add_byte(8'h00);
    // Empty template and zero component lengths, decryption slot, widest command length.
    add_begin(16'hFFFF);
    add_byte(TagOuter[7:0]);
    add_byte(8'h00);
    add_byte(TagSlotDec[7:0]);
    add_byte(8'h00);
    add_byte(TagTemplate[15:8]);
    add_byte(TagTemplate[7:0]);
    add_byte(8'h00);
    add_byte(TagKeyData[15:8]);
    add_byte(TagKeyData[7:0]);
    add_byte(8'h00);
    // A length byte of an unknown form.
    add_begin(16'h0000);
    add_byte(TagOuter[7:0]);
    add_byte(8'h83);
    // An unknown key slot tag.
    add_begin(16'h0000);
    add_byte(TagOuter[7:0]);
    add_byte(8'h00);
    add_byte(8'hC1);
    add_byte(8'h00);
    // Random commands.
    while (stim_q.size() < RandomItems) make_command();

    repeat (4) @(negedge clk);
    rst = 1'b0;

    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      if (!paused && n_sent >= PauseAfter && !it.op) begin
        // Hold the next begin until every pending record has been taken.
        paused = 1'b1;
        s_tvalid = 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) burst = !burst;
        g = (burst || $urandom_range(0, 1)) ? 0 : gap_len();
        if (g != 0) begin
          s_tvalid = 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      send_item(it);
      n_sent++;
    end
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d commands in %0d input transactions: %0d gave seven key records,",
             sb.begins, sb.inputs, sb.good_runs);
    $display("%0d gave an error record; %0d output records were checked.",
             sb.error_runs, sb.records_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
design/kihlp_pkg.sv
design/kihlp_dp.sv
design/kihlp_ctrl.sv
design/key_import_header_list_parser_unit.sv
tb/sv/tb_key_import_header_list_parser_unit.sv
